// ===== design/jac7_pkg.sv =====
// Shared constants, types and helper functions of the 3-D Jacobi 7-point sweep.
`default_nettype none

package jac7_pkg;

  localparam int MAX_X = 64;
  localparam int MAX_Y = 64;
  localparam int MAX_Z = 64;
  localparam int MAX_XYZ = (MAX_X > MAX_Y) ? ((MAX_X > MAX_Z) ? MAX_X : MAX_Z)
                                           : ((MAX_Y > MAX_Z) ? MAX_Y : MAX_Z);

  localparam int DATA_W  = 32;
  localparam int SIZE_W  = 7;
  localparam int POS_W   = $clog2(MAX_XYZ);

  localparam int PLANE_MAX = MAX_X * MAX_Y;
  localparam int PLANE_W   = $clog2(PLANE_MAX + 1);
  localparam int DEPTH     = 2 * PLANE_MAX + 1;
  localparam int HELD_W    = $clog2(DEPTH + 1);
  localparam int BUF_AW    = HELD_W;
  localparam int AGE_W     = HELD_W + 2;

  localparam int N_REG  = 3;
  localparam int ADDR_W = $clog2(4 * N_REG);
  localparam int IDX_W  = ADDR_W - 2;

  localparam logic [IDX_W-1:0] REG_SIZE_X = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_SIZE_Y = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_SIZE_Z = IDX_W'(2);

  localparam int RST_X = 10;
  localparam int RST_Y = 20;
  localparam int RST_Z = 10;
  localparam logic [PLANE_W-1:0] RST_PLANE = PLANE_W'(RST_X * RST_Y);

  // Tap order: center, then x, y and z neighbors
  localparam int NTAP   = 7;
  localparam int TAP_C  = 0;
  localparam int TAP_XP = 1;
  localparam int TAP_XM = 2;
  localparam int TAP_YP = 3;
  localparam int TAP_YM = 4;
  localparam int TAP_ZP = 5;
  localparam int TAP_ZM = 6;

  localparam int SUM_W  = DATA_W + 4;
  localparam int N_NIB  = SUM_W / 4;
  localparam int HI_NIB = 5;
  localparam int LO_NIB = N_NIB - HI_NIB;
  localparam int HI_W   = 4 * HI_NIB;
  localparam int LO_W   = 4 * LO_NIB;

  typedef struct packed {
    logic vld;
    logic bnd;
    logic last;
  } jac7_ctl_t;

  function automatic logic [SIZE_W-1:0] size_eff(input logic [SIZE_W-1:0] v,
                                                 input int maxv);
    logic [SIZE_W-1:0] r;
    if (v < SIZE_W'(3)) begin
      r = SIZE_W'(3);
    end else if (int'(v) > maxv) begin
      r = SIZE_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // One radix-16 digit of a divide by six: {quotient digit, remainder}
  function automatic logic [6:0] div6_step(input logic [2:0] rem, input logic [3:0] nib);
    logic [6:0] v;
    logic [3:0] q;
    logic [6:0] r;
    v = {rem, nib};
    q = '0;
    for (int k = 1; k < 16; k++) begin
      if (v >= 7'(6 * k)) q = 4'(k);
    end
    r = v - 7'({q, 2'b00}) - 7'({q, 1'b0});
    return {q, r[2:0]};
  endfunction

endpackage

`default_nettype wire

// ===== design/jac7_ram.sv =====
// Generic one-write, multi-read memory with registered read data.
`default_nettype none

module jac7_ram #(
  parameter int AW  = 14,
  parameter int DW  = 32,
  parameter int NRD = 2
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          re,
  input  logic [AW-1:0] rd_addr [NRD],
  output logic [DW-1:0] rd_data [NRD]
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      for (int i = 0; i < NRD; i++) begin
        rd_data[i] <= mem[rd_addr[i]];
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/jac7_update.sv =====
// Stencil arithmetic: tap sum, divide by six toward zero, add center, saturate.
`default_nettype none

module jac7_update (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  jac7_pkg::jac7_ctl_t                 in_ctl,
  input  logic signed [jac7_pkg::DATA_W-1:0]  taps [jac7_pkg::NTAP],
  output jac7_pkg::jac7_ctl_t                 res_ctl,
  output logic signed [jac7_pkg::DATA_W-1:0]  res_value
);
  import jac7_pkg::*;

  logic signed [SUM_W-1:0] ext [NTAP];
  logic signed [SUM_W-1:0] sum;

  jac7_ctl_t               s2_ctl_r;
  logic signed [DATA_W-1:0] s2_c_r;
  logic signed [SUM_W-1:0] s2_sum_r;

  logic [SUM_W-1:0]        mag;
  logic [HI_W-1:0]         qh;
  logic [2:0]              rem_h;
  logic [6:0]              step_h;

  jac7_ctl_t               s3_ctl_r;
  logic signed [DATA_W-1:0] s3_c_r;
  logic [HI_W-1:0]         s3_qh_r;
  logic [2:0]              s3_rem_r;
  logic [LO_W-1:0]         s3_lo_r;
  logic                    s3_neg_r;

  logic [LO_W-1:0]         ql;
  logic [2:0]              rem_l;
  logic [6:0]              step_l;
  logic [SUM_W-1:0]        q;
  logic [SUM_W-1:0]        qs;
  logic signed [SUM_W:0]   res_w;
  logic                    ovf;

  always_comb begin
    for (int i = 0; i < NTAP; i++) begin
      ext[i] = SUM_W'(taps[i]);
    end
    sum = ext[TAP_XP] + ext[TAP_XM] + ext[TAP_YP] + ext[TAP_YM] + ext[TAP_ZP] +
          ext[TAP_ZM] - (ext[TAP_C] <<< 2) - (ext[TAP_C] <<< 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r.vld <= 1'b0;
    end else if (en) begin
      s2_ctl_r.vld <= in_ctl.vld;
    end
    if (en) begin
      s2_ctl_r.bnd  <= in_ctl.bnd;
      s2_ctl_r.last <= in_ctl.last;
      s2_c_r        <= taps[TAP_C];
      s2_sum_r      <= sum;
    end
  end

  // high digits of the quotient
  always_comb begin
    mag    = s2_sum_r[SUM_W-1] ? SUM_W'(-s2_sum_r) : SUM_W'(s2_sum_r);
    qh     = '0;
    rem_h  = '0;
    step_h = '0;
    for (int i = 0; i < HI_NIB; i++) begin
      step_h = div6_step(rem_h, mag[SUM_W-1-4*i -: 4]);
      qh[HI_W-1-4*i -: 4] = step_h[6:3];
      rem_h = step_h[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctl_r.vld <= 1'b0;
    end else if (en) begin
      s3_ctl_r.vld <= s2_ctl_r.vld;
    end
    if (en) begin
      s3_ctl_r.bnd  <= s2_ctl_r.bnd;
      s3_ctl_r.last <= s2_ctl_r.last;
      s3_c_r        <= s2_c_r;
      s3_qh_r       <= qh;
      s3_rem_r      <= rem_h;
      s3_lo_r       <= mag[LO_W-1:0];
      s3_neg_r      <= s2_sum_r[SUM_W-1];
    end
  end

  // low digits, sign, center add and saturation
  always_comb begin
    ql     = '0;
    rem_l  = s3_rem_r;
    step_l = '0;
    for (int i = 0; i < LO_NIB; i++) begin
      step_l = div6_step(rem_l, s3_lo_r[LO_W-1-4*i -: 4]);
      ql[LO_W-1-4*i -: 4] = step_l[6:3];
      rem_l = step_l[2:0];
    end
    q     = {s3_qh_r, ql};
    qs    = s3_neg_r ? (~q + SUM_W'(1)) : q;
    res_w = (SUM_W+1)'(s3_c_r) + (SUM_W+1)'(signed'(qs));
    ovf   = res_w[SUM_W:DATA_W-1] != {(SUM_W-DATA_W+2){res_w[DATA_W-1]}};
    if (ovf) begin
      res_value = res_w[SUM_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      res_value = res_w[DATA_W-1:0];
    end
    res_ctl = s3_ctl_r;
  end

endmodule

`default_nettype wire

// ===== design/stencil7_jacobi_sweep_3d_top.sv =====
// Top level of the streaming 3-D Jacobi 7-point sweep.
`default_nettype none

// While in_stall is low it takes one grid value per cycle (x fastest, then y,
// then z), flush transfers (in_mode = 1) drain the pending plane at one result
// per cycle, and throughput is one transfer per clock. It returns one updated
// cell per emitting transfer; face cells come out as zero. A result trails its
// sample by one plane (clamped size_x*size_y cells). An emitting transfer loads
// the tap read register, followed by three arithmetic stages. The window is a
// 16K-word circular buffer kept in four identical copies so that all seven taps
// are read in the same cycle. Its contents start undefined and need no clearing
// pass. in_stall is high only while the output register holds a result that the
// sink stalls. Sizes must be written over the APB port only while the stream is
// idle; the block does not enforce this.
module stencil7_jacobi_sweep_3d_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [jac7_pkg::ADDR_W-1:0]          paddr,
  input  logic [jac7_pkg::DATA_W-1:0]          pwdata,
  output logic [jac7_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_mode,
  input  logic signed [jac7_pkg::DATA_W-1:0]   in_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [jac7_pkg::DATA_W-1:0]   out_value,
  output logic                                 out_last
);
  import jac7_pkg::*;

  // configuration
  logic                 wr;
  logic [IDX_W-1:0]     idx;
  logic [SIZE_W-1:0]    size_x_r, size_y_r, size_z_r;
  logic [SIZE_W-1:0]    size_x_nxt, size_y_nxt, size_z_nxt;
  logic [SIZE_W-1:0]    eff_x_r, eff_y_r, eff_z_r;
  logic [SIZE_W-1:0]    eff_x_nxt, eff_y_nxt, eff_z_nxt;
  logic [PLANE_W-1:0]   plane_r, plane_nxt;
  logic [2*SIZE_W-1:0]  plane_prod;

  // stream control
  logic                 en, acc, smp, emit, bnd, last;
  logic [HELD_W-1:0]    held_r, held_nxt, held_inc;
  logic [BUF_AW-1:0]    wp_r, wp_nxt, wp_cur;
  logic [POS_W-1:0]     ox_r, oy_r, oz_r, ox_nxt, oy_nxt, oz_nxt;
  logic [SIZE_W-1:0]    ex_m1, ey_m1, ez_m1;
  logic                 x_end, y_end, z_end;
  logic [AGE_W-1:0]     age_d, ex_a, pl_a;
  logic [AGE_W-1:0]     age [NTAP];
  logic [BUF_AW-1:0]    ra [NTAP];
  logic [NTAP-1:0]      tv, byp;

  // tap read stage
  jac7_ctl_t            s1_ctl_r;
  logic [NTAP-1:0]      s1_tv_r, s1_byp_r;
  logic [DATA_W-1:0]    s1_smp_r;
  logic [BUF_AW-1:0]    ra0 [2], ra1 [2], ra2 [2], ra3 [1];
  logic [DATA_W-1:0]    rd0 [2], rd1 [2], rd2 [2], rd3 [1];
  logic [DATA_W-1:0]    rdat [NTAP];
  logic signed [DATA_W-1:0] taps [NTAP];

  jac7_ctl_t            res_ctl;
  logic signed [DATA_W-1:0] res_value;

  logic                 out_valid_r, out_last_r;
  logic signed [DATA_W-1:0] out_value_r;

  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;

  always_comb begin
    size_x_nxt = size_x_r;
    size_y_nxt = size_y_r;
    size_z_nxt = size_z_r;
    eff_x_nxt  = eff_x_r;
    eff_y_nxt  = eff_y_r;
    eff_z_nxt  = eff_z_r;
    if (wr) begin
      unique case (idx)
        REG_SIZE_X: begin
          size_x_nxt = pwdata[SIZE_W-1:0];
          eff_x_nxt  = size_eff(pwdata[SIZE_W-1:0], MAX_X);
        end
        REG_SIZE_Y: begin
          size_y_nxt = pwdata[SIZE_W-1:0];
          eff_y_nxt  = size_eff(pwdata[SIZE_W-1:0], MAX_Y);
        end
        REG_SIZE_Z: begin
          size_z_nxt = pwdata[SIZE_W-1:0];
          eff_z_nxt  = size_eff(pwdata[SIZE_W-1:0], MAX_Z);
        end
        default: ;
      endcase
    end
    plane_prod = (2*SIZE_W)'(eff_x_nxt) * (2*SIZE_W)'(eff_y_nxt);
    plane_nxt  = plane_prod[PLANE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SIZE_W'(RST_X);
      size_y_r <= SIZE_W'(RST_Y);
      size_z_r <= SIZE_W'(RST_Z);
      eff_x_r  <= SIZE_W'(RST_X);
      eff_y_r  <= SIZE_W'(RST_Y);
      eff_z_r  <= SIZE_W'(RST_Z);
      plane_r  <= RST_PLANE;
    end else begin
      size_x_r <= size_x_nxt;
      size_y_r <= size_y_nxt;
      size_z_r <= size_z_nxt;
      eff_x_r  <= eff_x_nxt;
      eff_y_r  <= eff_y_nxt;
      eff_z_r  <= eff_z_nxt;
      plane_r  <= plane_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_SIZE_X: prdata = DATA_W'(size_x_r);
      REG_SIZE_Y: prdata = DATA_W'(size_y_r);
      REG_SIZE_Z: prdata = DATA_W'(size_z_r);
      default:    prdata = '0;
    endcase
  end

  // handshake
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;
  assign acc      = in_valid && en;
  assign smp      = acc && !in_mode;

  // window bookkeeping and tap addressing
  always_comb begin
    held_inc = (!in_mode && (held_r < HELD_W'(DEPTH))) ? held_r + HELD_W'(1) : held_r;
    emit     = in_mode ? (held_r != '0) : (held_inc > HELD_W'(plane_r));

    ex_m1 = eff_x_r - SIZE_W'(1);
    ey_m1 = eff_y_r - SIZE_W'(1);
    ez_m1 = eff_z_r - SIZE_W'(1);
    x_end = SIZE_W'(ox_r) >= ex_m1;
    y_end = SIZE_W'(oy_r) >= ey_m1;
    z_end = SIZE_W'(oz_r) >= ez_m1;
    bnd   = (ox_r == '0) || x_end || (oy_r == '0) || y_end || (oz_r == '0) || z_end;
    last  = x_end && y_end && z_end;

    age_d = AGE_W'(held_inc) - AGE_W'(1);
    ex_a  = AGE_W'(eff_x_r);
    pl_a  = AGE_W'(plane_r);
    age[TAP_C]  = age_d;
    age[TAP_XP] = age_d + AGE_W'(1);
    age[TAP_XM] = age_d - AGE_W'(1);
    age[TAP_YP] = age_d + ex_a;
    age[TAP_YM] = age_d - ex_a;
    age[TAP_ZP] = age_d + pl_a;
    age[TAP_ZM] = age_d - pl_a;

    wp_cur = in_mode ? wp_r : wp_r + BUF_AW'(1);
    for (int i = 0; i < NTAP; i++) begin
      ra[i]  = wp_cur - age[i][BUF_AW-1:0];
      tv[i]  = !age[i][AGE_W-1] && (age[i] < AGE_W'(DEPTH));
      byp[i] = !in_mode && (age[i] == '0);
    end

    held_nxt = held_r;
    wp_nxt   = wp_r;
    ox_nxt   = ox_r;
    oy_nxt   = oy_r;
    oz_nxt   = oz_r;
    if (acc) begin
      held_nxt = emit ? held_inc - HELD_W'(1) : held_inc;
      wp_nxt   = wp_cur;
      if (emit) begin
        if (x_end) begin
          ox_nxt = '0;
          if (y_end) begin
            oy_nxt = '0;
            oz_nxt = z_end ? '0 : oz_r + POS_W'(1);
          end else begin
            oy_nxt = oy_r + POS_W'(1);
          end
        end else begin
          ox_nxt = ox_r + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= '0;
      wp_r         <= '0;
      ox_r         <= '0;
      oy_r         <= '0;
      oz_r         <= '0;
      s1_ctl_r.vld <= 1'b0;
    end else begin
      held_r <= held_nxt;
      wp_r   <= wp_nxt;
      ox_r   <= ox_nxt;
      oy_r   <= oy_nxt;
      oz_r   <= oz_nxt;
      if (en) begin
        s1_ctl_r.vld <= acc && emit;
      end
    end
    if (en) begin
      s1_ctl_r.bnd  <= bnd;
      s1_ctl_r.last <= last;
      s1_tv_r       <= tv;
      s1_byp_r      <= byp;
      s1_smp_r      <= in_sample;
    end
  end

  // four window copies, seven read ports
  assign ra0[0] = ra[TAP_C];
  assign ra0[1] = ra[TAP_XP];
  assign ra1[0] = ra[TAP_XM];
  assign ra1[1] = ra[TAP_YP];
  assign ra2[0] = ra[TAP_YM];
  assign ra2[1] = ra[TAP_ZP];
  assign ra3[0] = ra[TAP_ZM];

  jac7_ram #(.AW(BUF_AW), .DW(DATA_W), .NRD(2)) u_win0 (
    .clk(clk), .we(smp), .wr_addr(wp_cur), .wr_data(in_sample),
    .re(en), .rd_addr(ra0), .rd_data(rd0)
  );
  jac7_ram #(.AW(BUF_AW), .DW(DATA_W), .NRD(2)) u_win1 (
    .clk(clk), .we(smp), .wr_addr(wp_cur), .wr_data(in_sample),
    .re(en), .rd_addr(ra1), .rd_data(rd1)
  );
  jac7_ram #(.AW(BUF_AW), .DW(DATA_W), .NRD(2)) u_win2 (
    .clk(clk), .we(smp), .wr_addr(wp_cur), .wr_data(in_sample),
    .re(en), .rd_addr(ra2), .rd_data(rd2)
  );
  jac7_ram #(.AW(BUF_AW), .DW(DATA_W), .NRD(1)) u_win3 (
    .clk(clk), .we(smp), .wr_addr(wp_cur), .wr_data(in_sample),
    .re(en), .rd_addr(ra3), .rd_data(rd3)
  );

  // the newest sample is written on the same edge it is read: forward it
  always_comb begin
    rdat[TAP_C]  = rd0[0];
    rdat[TAP_XP] = rd0[1];
    rdat[TAP_XM] = rd1[0];
    rdat[TAP_YP] = rd1[1];
    rdat[TAP_YM] = rd2[0];
    rdat[TAP_ZP] = rd2[1];
    rdat[TAP_ZM] = rd3[0];
    for (int i = 0; i < NTAP; i++) begin
      if (!s1_tv_r[i]) begin
        taps[i] = '0;
      end else if (s1_byp_r[i]) begin
        taps[i] = s1_smp_r;
      end else begin
        taps[i] = rdat[i];
      end
    end
  end

  jac7_update u_update (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_ctl   (s1_ctl_r),
    .taps     (taps),
    .res_ctl  (res_ctl),
    .res_value(res_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= res_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value_r <= res_ctl.bnd ? '0 : res_value;
      out_last_r  <= res_ctl.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire
